### sv/tsbb_pkg.sv
// ----------------------------------------------------------------------------
// tsbb_pkg
// Shared types and constants for the transformed shape bounding box core.
// ----------------------------------------------------------------------------
package tsbb_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int TRIG_FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic ACTION_VERTEX = 1'b0;
    localparam logic ACTION_CIRCLE = 1'b1;

    // Classified request kind carried from front to back
    typedef enum logic [1:0] {
        OP_VERTEX = 2'd0,
        OP_LAST   = 2'd1,
        OP_CIRCLE = 2'd2
    } op_kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_COS   = 2'd0,
        REG_SIN   = 2'd1,
        REG_POS_X = 2'd2,
        REG_POS_Y = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### sv/tsbb_front.sv
// ----------------------------------------------------------------------------
// tsbb_front
// Accepts shape requests, classifies them and forms the four rotation products.
// ----------------------------------------------------------------------------
module tsbb_front
    import tsbb_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int TW = TRIG_FRAC_BITS + 2,
    localparam int PW = TW + COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic        [COORD_WIDTH-2:0] s_radius,
    input  logic                          s_last_vertex,
    input  logic signed [TW-1:0]          cos_angle,
    input  logic signed [TW-1:0]          sin_angle,
    output logic                          push_valid,
    input  logic                          push_ready,
    output op_kind_t                      push_kind,
    output logic        [COORD_WIDTH-2:0] push_radius,
    output logic signed [PW-1:0]          push_cx,
    output logic signed [PW-1:0]          push_sy,
    output logic signed [PW-1:0]          push_sx,
    output logic signed [PW-1:0]          push_cy
);

    logic            valid_reg;
    logic            valid_next;
    logic            load;
    op_kind_t        kind_reg;
    logic [COORD_WIDTH-2:0] radius_reg;
    logic signed [PW-1:0] cx_reg, sy_reg, sx_reg, cy_reg;

    assign s_ready = !valid_reg || push_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            if (s_action == ACTION_CIRCLE) begin
                kind_reg <= OP_CIRCLE;
            end else if (s_last_vertex) begin
                kind_reg <= OP_LAST;
            end else begin
                kind_reg <= OP_VERTEX;
            end
            radius_reg <= s_radius;
            cx_reg     <= cos_angle * s_point_x;
            sy_reg     <= sin_angle * s_point_y;
            sx_reg     <= sin_angle * s_point_x;
            cy_reg     <= cos_angle * s_point_y;
        end
    end

    assign push_valid  = valid_reg;
    assign push_kind   = kind_reg;
    assign push_radius = radius_reg;
    assign push_cx     = cx_reg;
    assign push_sy     = sy_reg;
    assign push_sx     = sx_reg;
    assign push_cy     = cy_reg;

endmodule

### sv/tsbb_queue.sv
// ----------------------------------------------------------------------------
// tsbb_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module tsbb_queue
    import tsbb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    assign status.full  = !push_ready;
    assign status.empty = !pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/tsbb_back.sv
// ----------------------------------------------------------------------------
// tsbb_back
// Rounds and translates the rotated point, then folds it into the box
// trackers or builds a circle box, with a registered result stage.
// ----------------------------------------------------------------------------
module tsbb_back
    import tsbb_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int TW = TRIG_FRAC_BITS + 2,
    localparam int PW = TW + COORD_WIDTH,
    localparam int QW = 4 * PW + COORD_WIDTH + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  logic [QW-1:0]                 pop_data,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_box_min_x,
    output logic signed [COORD_WIDTH-1:0] m_box_min_y,
    output logic signed [COORD_WIDTH-1:0] m_box_max_x,
    output logic signed [COORD_WIDTH-1:0] m_box_max_y
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = PW + 2;   // exact sum of two products plus rounding
    localparam int RW = SW - TRIG_FRAC_BITS;
    localparam int EW = RW + 1;   // rotated value plus translation
    localparam logic signed [SW-1:0] HALF = SW'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW - 1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_point(input logic signed [EW-1:0] v);
        if (v[EW-1:CW-1] == {(EW - CW + 1){1'b0}} || v[EW-1:CW-1] == {(EW - CW + 1){1'b1}}) begin
            return v[CW-1:0];
        end else if (v[EW-1]) begin
            return CMIN;
        end else begin
            return CMAX;
        end
    endfunction

    function automatic logic signed [CW-1:0] sat_edge(input logic signed [CW:0] v);
        if (v[CW] == v[CW-1]) begin
            return v[CW-1:0];
        end else if (v[CW]) begin
            return CMIN;
        end else begin
            return CMAX;
        end
    endfunction

    // Queue entry fields
    op_kind_t             q_kind;
    logic [CW-2:0]        q_radius;
    logic signed [PW-1:0] q_cx, q_sy, q_sx, q_cy;

    assign q_cy     = pop_data[PW-1:0];
    assign q_sx     = pop_data[2*PW-1:PW];
    assign q_sy     = pop_data[3*PW-1:2*PW];
    assign q_cx     = pop_data[4*PW-1:3*PW];
    assign q_radius = pop_data[4*PW+CW-2:4*PW];
    assign q_kind   = op_kind_t'(pop_data[QW-1:QW-2]);

    // Rotate, round half up, translate, saturate
    logic signed [SW-1:0] sum_x, sum_y, rnd_x, rnd_y;
    logic signed [RW-1:0] rot_x, rot_y;
    logic signed [EW-1:0] wide_x, wide_y;

    assign sum_x  = SW'(q_cx) - SW'(q_sy);
    assign sum_y  = SW'(q_sx) + SW'(q_cy);
    assign rnd_x  = (sum_x + HALF) >>> TRIG_FRAC_BITS;
    assign rnd_y  = (sum_y + HALF) >>> TRIG_FRAC_BITS;
    assign rot_x  = rnd_x[RW-1:0];
    assign rot_y  = rnd_y[RW-1:0];
    assign wide_x = EW'(rot_x) + EW'(pos_x);
    assign wide_y = EW'(rot_y) + EW'(pos_y);

    // Transform stage
    logic                 a_valid_reg, a_valid_next;
    op_kind_t             a_kind_reg;
    logic [CW-2:0]        a_radius_reg;
    logic signed [CW-1:0] a_tx_reg, a_ty_reg;
    logic                 a_fire, a_load;

    // Vertex stays local; last vertex and circle need the result register
    assign a_fire    = a_valid_reg && (a_kind_reg == OP_VERTEX || !m_valid || m_ready);
    assign pop_ready = !a_valid_reg || a_fire;
    assign a_load    = pop_valid && pop_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_load) begin
            a_valid_next = 1'b1;
        end else if (a_fire) begin
            a_valid_next = 1'b0;
        end
    end

    // Trackers and result register
    logic signed [CW-1:0] run_min_x_reg, run_min_y_reg, run_max_x_reg, run_max_y_reg;
    logic signed [CW-1:0] run_min_x_next, run_min_y_next, run_max_x_next, run_max_y_next;
    logic signed [CW-1:0] fold_min_x, fold_min_y, fold_max_x, fold_max_y;
    logic signed [CW:0]   rad_ext;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_load;
    logic signed [CW-1:0] m_min_x_reg, m_min_y_reg, m_max_x_reg, m_max_y_reg;

    assign fold_min_x = (a_tx_reg < run_min_x_reg) ? a_tx_reg : run_min_x_reg;
    assign fold_min_y = (a_ty_reg < run_min_y_reg) ? a_ty_reg : run_min_y_reg;
    assign fold_max_x = (a_tx_reg > run_max_x_reg) ? a_tx_reg : run_max_x_reg;
    assign fold_max_y = (a_ty_reg > run_max_y_reg) ? a_ty_reg : run_max_y_reg;
    assign rad_ext    = $signed({2'b00, a_radius_reg});
    assign m_load     = a_fire && (a_kind_reg != OP_VERTEX);

    always_comb begin
        run_min_x_next = run_min_x_reg;
        run_min_y_next = run_min_y_reg;
        run_max_x_next = run_max_x_reg;
        run_max_y_next = run_max_y_reg;
        if (a_fire) begin
            unique case (a_kind_reg)
                OP_VERTEX: begin
                    run_min_x_next = fold_min_x;
                    run_min_y_next = fold_min_y;
                    run_max_x_next = fold_max_x;
                    run_max_y_next = fold_max_y;
                end
                OP_LAST: begin
                    run_min_x_next = CMAX;
                    run_min_y_next = CMAX;
                    run_max_x_next = CMIN;
                    run_max_y_next = CMIN;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            run_min_x_reg <= CMAX;
            run_min_y_reg <= CMAX;
            run_max_x_reg <= CMIN;
            run_max_y_reg <= CMIN;
        end else begin
            a_valid_reg   <= a_valid_next;
            m_valid_reg   <= m_valid_next;
            run_min_x_reg <= run_min_x_next;
            run_min_y_reg <= run_min_y_next;
            run_max_x_reg <= run_max_x_next;
            run_max_y_reg <= run_max_y_next;
        end
        if (a_load) begin
            a_kind_reg   <= q_kind;
            a_radius_reg <= q_radius;
            a_tx_reg     <= sat_point(wide_x);
            a_ty_reg     <= sat_point(wide_y);
        end
        if (m_load) begin
            if (a_kind_reg == OP_CIRCLE) begin
                m_min_x_reg <= sat_edge((CW + 1)'(a_tx_reg) - rad_ext);
                m_min_y_reg <= sat_edge((CW + 1)'(a_ty_reg) - rad_ext);
                m_max_x_reg <= sat_edge((CW + 1)'(a_tx_reg) + rad_ext);
                m_max_y_reg <= sat_edge((CW + 1)'(a_ty_reg) + rad_ext);
            end else begin
                m_min_x_reg <= fold_min_x;
                m_min_y_reg <= fold_min_y;
                m_max_x_reg <= fold_max_x;
                m_max_y_reg <= fold_max_y;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_box_min_x = m_min_x_reg;
    assign m_box_min_y = m_min_y_reg;
    assign m_box_max_x = m_max_x_reg;
    assign m_box_max_y = m_max_y_reg;

endmodule

### sv/transformed_shape_bounding_box_core.sv
// ----------------------------------------------------------------------------
// transformed_shape_bounding_box_core
// Axis-aligned box of polygons and circles under a rigid body pose.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  s_*       s_valid / s_ready    action, point_x, point_y, radius, last_vertex
//  m_*       m_valid / m_ready    box_min_x, box_min_y, box_max_x, box_max_y
//  cfg_*     cfg_wr_en            cfg_index, cfg_data
//
// One request per cycle unless results stall; the rotation multipliers and
// the tracker update each sit in their own stage. m_valid rises after the
// queue and the transform stage. A vertex that is not last produces no
// result and never waits on m_ready. Reset is synchronous, active low, and
// re-arms the trackers; a stalled result fills the queue before s_ready drops.
// ----------------------------------------------------------------------------
module transformed_shape_bounding_box_core
    import tsbb_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int TW    = TRIG_FRAC_BITS + 2,
    localparam int CFG_W = (COORD_WIDTH > TW) ? COORD_WIDTH : TW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic        [COORD_WIDTH-2:0] s_radius,
    input  logic                          s_last_vertex,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_box_min_x,
    output logic signed [COORD_WIDTH-1:0] m_box_min_y,
    output logic signed [COORD_WIDTH-1:0] m_box_max_x,
    output logic signed [COORD_WIDTH-1:0] m_box_max_y
);

    localparam int PW = TW + COORD_WIDTH;
    localparam int QW = 4 * PW + COORD_WIDTH + 1;
    localparam logic signed [TW-1:0] COS_RESET = TW'(1) << TRIG_FRAC_BITS;

    // Pose registers
    logic signed [TW-1:0]          cos_reg, sin_reg;
    logic signed [COORD_WIDTH-1:0] pos_x_reg, pos_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg   <= COS_RESET;
            sin_reg   <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COS:   cos_reg   <= cfg_data[TW-1:0];
                REG_SIN:   sin_reg   <= cfg_data[TW-1:0];
                REG_POS_X: pos_x_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_POS_Y: pos_y_reg <= cfg_data[COORD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    logic                          push_valid, push_ready;
    op_kind_t                      push_kind;
    logic        [COORD_WIDTH-2:0] push_radius;
    logic signed [PW-1:0]          push_cx, push_sy, push_sx, push_cy;
    logic                          pop_valid, pop_ready;
    logic [QW-1:0]                 pop_data;
    queue_status_t                 q_status;

    tsbb_front #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_radius      (s_radius),
        .s_last_vertex (s_last_vertex),
        .cos_angle     (cos_reg),
        .sin_angle     (sin_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_kind     (push_kind),
        .push_radius   (push_radius),
        .push_cx       (push_cx),
        .push_sy       (push_sy),
        .push_sx       (push_sx),
        .push_cy       (push_cy)
    );

    tsbb_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_kind, push_radius, push_cx, push_sy, push_sx, push_cy}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .status     (q_status)
    );

    tsbb_back #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .pos_x       (pos_x_reg),
        .pos_y       (pos_y_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_box_min_x (m_box_min_x),
        .m_box_min_y (m_box_min_y),
        .m_box_max_x (m_box_max_x),
        .m_box_max_y (m_box_max_y)
    );

    // Checks
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    a_front_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (push_valid && q_status.full))
        else $error("input stalled without a full queue");

    a_pop_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for transformed_shape_bounding_box_core. A queue-fed
// driver offers shape requests, a random receiver takes boxes, and a
// predictor that rotates, rounds, translates and saturates each point keeps
// the boxes that must come back, in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import tsbb_pkg::*;

    localparam int CW             = COORD_WIDTH_DEF;
    localparam int PIPE_SETTLE    = 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 60;

    localparam logic signed [CW-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] COORD_MIN = 32'sh8000_0000;
    localparam longint ROUND_HALF = 64'sd1 <<< (TRIG_FRAC_BITS_DEF - 1);

    typedef struct {
        logic                 action;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic        [CW-2:0] radius;
        logic                 last;
    } shape_req_t;

    typedef struct {
        logic signed [CW-1:0] min_x;
        logic signed [CW-1:0] min_y;
        logic signed [CW-1:0] max_x;
        logic signed [CW-1:0] max_y;
    } box_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_index;
    logic [CW-1:0]        cfg_data;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = 1'b0;
    logic signed [CW-1:0] s_point_x = '0;
    logic signed [CW-1:0] s_point_y = '0;
    logic        [CW-2:0] s_radius = '0;
    logic                 s_last_vertex = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [CW-1:0] m_box_min_x;
    logic signed [CW-1:0] m_box_min_y;
    logic signed [CW-1:0] m_box_max_x;
    logic signed [CW-1:0] m_box_max_y;

    // pose as the block should hold it, and the running polygon extent
    logic signed [15:0]   pose_cos = 16'sd16384;
    logic signed [15:0]   pose_sin = 16'sd0;
    logic signed [CW-1:0] pose_x = '0;
    logic signed [CW-1:0] pose_y = '0;
    longint               trk_min_x, trk_min_y, trk_max_x, trk_max_y;

    shape_req_t req_q[$];
    box_t       pending_boxes[$];
    shape_req_t drv_req;
    logic       s_taken = 1'b0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       want_long_hold = 1'b0;
    int         hold_cnt = 0;
    int         errors = 0;
    int         quiet_cycles = 0;

    transformed_shape_bounding_box_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_radius      (s_radius),
        .s_last_vertex (s_last_vertex),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_box_min_x   (m_box_min_x),
        .m_box_min_y   (m_box_min_y),
        .m_box_max_x   (m_box_max_x),
        .m_box_max_y   (m_box_max_y)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp_coord(longint v);
        if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
        if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
        return v;
    endfunction

    task automatic arm_trackers();
        trk_min_x = longint'(COORD_MAX);
        trk_min_y = longint'(COORD_MAX);
        trk_max_x = longint'(COORD_MIN);
        trk_max_y = longint'(COORD_MIN);
    endtask

    // Called at the edge where a request is accepted; reads it off the ports.
    task automatic predict_box();
        longint acc_x, acc_y, tx, ty, rad;
        box_t   b;
        acc_x = longint'(pose_cos) * longint'(s_point_x)
              - longint'(pose_sin) * longint'(s_point_y);
        acc_y = longint'(pose_sin) * longint'(s_point_x)
              + longint'(pose_cos) * longint'(s_point_y);
        // add half then floor: ties go toward plus infinity
        tx = clamp_coord(((acc_x + ROUND_HALF) >>> TRIG_FRAC_BITS_DEF) + longint'(pose_x));
        ty = clamp_coord(((acc_y + ROUND_HALF) >>> TRIG_FRAC_BITS_DEF) + longint'(pose_y));
        if (s_action == ACTION_CIRCLE) begin
            rad = longint'(s_radius);
            b.min_x = CW'(clamp_coord(tx - rad));
            b.min_y = CW'(clamp_coord(ty - rad));
            b.max_x = CW'(clamp_coord(tx + rad));
            b.max_y = CW'(clamp_coord(ty + rad));
            pending_boxes.push_back(b);
        end else begin
            if (tx < trk_min_x) trk_min_x = tx;
            if (tx > trk_max_x) trk_max_x = tx;
            if (ty < trk_min_y) trk_min_y = ty;
            if (ty > trk_max_y) trk_max_y = ty;
            if (s_last_vertex) begin
                b.min_x = CW'(trk_min_x);
                b.min_y = CW'(trk_min_y);
                b.max_x = CW'(trk_max_x);
                b.max_y = CW'(trk_max_y);
                pending_boxes.push_back(b);
                arm_trackers();
            end
        end
    endtask

    task automatic check_field(string name, logic signed [CW-1:0] want,
                               logic signed [CW-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_box();
        box_t want;
        if (pending_boxes.size() == 0) begin
            $error("box result with no request pending");
            errors++;
        end else begin
            want = pending_boxes.pop_front();
            check_field("box_min_x", want.min_x, m_box_min_x);
            check_field("box_min_y", want.min_y, m_box_min_y);
            check_field("box_max_x", want.max_x, m_box_max_x);
            check_field("box_max_y", want.max_y, m_box_max_y);
        end
    endtask

    initial arm_trackers();

    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) check_box();
            if (s_valid && s_ready) predict_box();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // request driver: holds a request until taken, then maybe idles
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_req = req_q.pop_front();
                s_action      <= drv_req.action;
                s_point_x     <= drv_req.x;
                s_point_y     <= drv_req.y;
                s_radius      <= drv_req.radius;
                s_last_vertex <= drv_req.last;
                s_valid       <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // box receiver; one long hold-off lets the block back up into s_ready
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (want_long_hold && hold_cnt < LONG_HOLD) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(9))
            0:          return COORD_MAX;
            1:          return COORD_MIN;
            2, 3, 4, 5: return CW'($urandom_range(32'h3F_FFFF)) - 32'sh20_0000;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [CW-2:0] rand_radius();
        case ($urandom_range(9))
            0:             return '0;
            1:             return '1;
            2, 3, 4, 5, 6: return (CW-1)'($urandom_range(32'h1F_FFFF));
            default:       return (CW-1)'($urandom());
        endcase
    endfunction

    // low half is the Q2.14 value; the upper half must be ignored
    function automatic logic [CW-1:0] rand_trig();
        logic [15:0] v;
        case ($urandom_range(9))
            0:       v = 16'sd16384;
            1:       v = -16'sd16384;
            2:       v = '0;
            3:       v = 16'($urandom());
            default: v = 16'($urandom_range(32768)) - 16'd16384;
        endcase
        return {16'($urandom()), v};
    endfunction

    function automatic logic [CW-1:0] rand_pos();
        case ($urandom_range(9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3, 4, 5: return CW'($urandom_range(32'h3FF_FFFF)) - 32'sh200_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_req(logic action, logic signed [CW-1:0] x,
                            logic signed [CW-1:0] y, logic [CW-2:0] radius, logic last);
        shape_req_t r;
        r.action = action;
        r.x      = x;
        r.y      = y;
        r.radius = radius;
        r.last   = last;
        req_q.push_back(r);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_COS:   pose_cos = data[15:0];
            REG_SIN:   pose_sin = data[15:0];
            REG_POS_X: pose_x = data;
            REG_POS_Y: pose_y = data;
        endcase
    endtask

    task automatic set_pose(logic [CW-1:0] c, logic [CW-1:0] s,
                            logic [CW-1:0] px, logic [CW-1:0] py);
        write_reg(REG_COS, c);
        write_reg(REG_SIN, s);
        write_reg(REG_POS_X, px);
        write_reg(REG_POS_Y, py);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every request is taken and every box is back, then lets a
    // trailing non-last vertex clear the pipeline.
    task automatic wait_drained();
        @(posedge aclk);
        while (req_q.size() != 0 || s_valid || pending_boxes.size() != 0)
            @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // Mostly whole polygons and circles; some requests with random flags.
    task automatic add_random_shapes(int count);
        int added;
        int n;
        int pick;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                push_req(ACTION_CIRCLE, rand_coord(), rand_coord(), rand_radius(),
                         1'($urandom()));
                added++;
            end else if (pick < 85) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_req(ACTION_VERTEX, rand_coord(), rand_coord(), rand_radius(),
                             i == n - 1);
                added += n;
            end else begin
                push_req(1'($urandom()), rand_coord(), rand_coord(), rand_radius(),
                         1'($urandom()));
                added++;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_COS;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset pose: identity
        push_req(ACTION_CIRCLE, 0, 0, 0, 1'b0);
        push_req(ACTION_CIRCLE, COORD_MAX, COORD_MIN, '1, 1'b1);
        push_req(ACTION_CIRCLE, COORD_MIN, COORD_MAX, '1, 1'b0);
        push_req(ACTION_VERTEX, COORD_MAX, COORD_MIN, '1, 1'b0);
        // circle inside a polygon must leave the trackers alone
        push_req(ACTION_CIRCLE, 32'sh5_0000, -32'sh3_0000, 31'h1_0000, 1'b1);
        push_req(ACTION_VERTEX, COORD_MIN, COORD_MAX, '0, 1'b0);
        push_req(ACTION_VERTEX, 0, 0, 0, 1'b1);
        push_req(ACTION_VERTEX, 123, -456, 0, 1'b1);
        wait_drained();

        set_pose(32'hFFFF_C000, 32'hFFFF_4000, COORD_MAX, COORD_MIN);
        push_req(ACTION_VERTEX, COORD_MAX, COORD_MAX, 0, 1'b0);
        push_req(ACTION_VERTEX, COORD_MIN, COORD_MIN, 0, 1'b0);
        push_req(ACTION_VERTEX, 1, -1, 0, 1'b1);
        push_req(ACTION_CIRCLE, 32'sh1_0000, 32'sh2_0000, '1, 1'b0);
        wait_drained();

        // trig words outside the Q2.14 range are taken as raw 16 bit values
        set_pose(32'hABCD_8000, 32'h1234_7FFF, 0, COORD_MIN);
        push_req(ACTION_VERTEX, COORD_MIN, COORD_MIN, 0, 1'b1);
        push_req(ACTION_CIRCLE, COORD_MAX, COORD_MIN, 0, 1'b0);
        wait_drained();

        // rounding ties
        set_pose(32'h0000_0001, 32'h0000_FFFF, 0, 0);
        push_req(ACTION_VERTEX, 8192, 0, 0, 1'b1);
        push_req(ACTION_VERTEX, -8192, 0, 0, 1'b1);
        push_req(ACTION_VERTEX, -8193, 8192, 0, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            set_pose(rand_trig(), rand_trig(), rand_pos(), rand_pos());
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (phase == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                want_long_hold = 1'b1;
            end
            add_random_shapes(PHASE_ITEMS);
            wait_drained();
        end

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
